[rtl/indexed_bit_op_unit_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef INDEXED_BIT_OP_UNIT_TOP_DEFINES_SVH
`define INDEXED_BIT_OP_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define IBO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define IBO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ibo_pkg.sv]
package ibo_pkg;

  // Word widths on the stream ports
  localparam int IN_W      = 48;
  localparam int OUT_W     = 48;
  localparam int OUT_USED  = 42;
  localparam int OUT_PAD_W = OUT_W - OUT_USED;

  // Opcode group, bits 7-6 of the CB byte
  typedef enum logic [1:0] {
    GRP_SHIFT = 2'd0,
    GRP_BIT   = 2'd1,
    GRP_RES   = 2'd2,
    GRP_SET   = 2'd3
  } grp_t;

  // Rotate / shift operation, bits 5-3 in the shift group
  typedef enum logic [2:0] {
    OP_RLC = 3'd0,
    OP_RRC = 3'd1,
    OP_RL  = 3'd2,
    OP_RR  = 3'd3,
    OP_SLA = 3'd4,
    OP_SRA = 3'd5,
    OP_SLL = 3'd6,
    OP_SRL = 3'd7
  } sft_op_t;

  // Register code meaning (HL) only, no register copy
  localparam logic [2:0] REG_MEM_ONLY = 3'd6;
  // Bit number whose test drives S in BIT
  localparam logic [2:0] BIT_SIGN     = 3'd7;

  // T-state counts
  localparam logic [4:0] CYC_WRITE = 5'd23;
  localparam logic [4:0] CYC_BIT   = 5'd20;

  // Input word, last field in the low bits
  typedef struct packed {
    logic [7:0]  flags_in;
    logic [7:0]  mem_byte;
    logic [15:0] index_value;
    logic [7:0]  command;
    logic [7:0]  displacement;
  } in_word_t;

  // Output word, last field in the low bits
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [4:0]           cycle_count;
    logic [7:0]           flags_out;
    logic [2:0]           reg_select;
    logic                 reg_write;
    logic [7:0]           write_byte;
    logic                 mem_write;
    logic [15:0]          mem_address;
  } out_word_t;

  // Decode stage contents
  typedef struct packed {
    logic [15:0] addr;
    grp_t        grp;
    logic [2:0]  sel;
    logic [2:0]  rc;
    logic [7:0]  mask;
    logic [7:0]  val;
    logic [7:0]  flags;
  } s1_t;

  // Execute stage contents
  typedef struct packed {
    logic [15:0] addr;
    grp_t        grp;
    logic [7:0]  res;
    logic        cout;
    logic        bit_set;
    logic        bit_sign;
    logic [7:0]  flags;
    logic        mw;
    logic        rw;
    logic [2:0]  rs;
    logic [4:0]  cyc;
  } s2_t;

endpackage

[rtl/ibo_decode.sv]
module ibo_decode
  import ibo_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  in_word_t up_word,
  output logic     dn_valid,
  input  logic     dn_ready,
  output s1_t      dn_data
);

  logic valid_r, valid_nxt;
  s1_t  data_r, data_nxt;
  logic [15:0] sext;

  assign up_ready = !valid_r || dn_ready;

  // Effective address and field decode
  always_comb begin
    sext = {{8{up_word.displacement[7]}}, up_word.displacement};
    data_nxt.addr  = up_word.index_value + sext;
    data_nxt.grp   = grp_t'(up_word.command[7:6]);
    data_nxt.sel   = up_word.command[5:3];
    data_nxt.rc    = up_word.command[2:0];
    data_nxt.mask  = 8'd1 << up_word.command[5:3];
    data_nxt.val   = up_word.mem_byte;
    data_nxt.flags = up_word.flags_in;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[rtl/ibo_exec.sv]
module ibo_exec
  import ibo_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  s1_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output s2_t  dn_data
);

  logic valid_r, valid_nxt;
  s2_t  data_r, data_nxt;
  logic [7:0] v;
  logic       cin;
  logic       writes;

  assign up_ready = !valid_r || dn_ready;

  // Result byte, shifted-out bit and write controls
  always_comb begin
    v      = up_data.val;
    cin    = up_data.flags[0];
    writes = (up_data.grp != GRP_BIT);
    data_nxt.addr     = up_data.addr;
    data_nxt.grp      = up_data.grp;
    data_nxt.flags    = up_data.flags;
    data_nxt.bit_set  = |(v & up_data.mask);
    data_nxt.bit_sign = (up_data.sel == BIT_SIGN);
    data_nxt.res      = 8'd0;
    data_nxt.cout     = 1'b0;
    case (up_data.grp)
      GRP_SHIFT: begin
        case (sft_op_t'(up_data.sel))
          OP_RLC:  begin data_nxt.res = {v[6:0], v[7]};  data_nxt.cout = v[7]; end
          OP_RRC:  begin data_nxt.res = {v[0], v[7:1]};  data_nxt.cout = v[0]; end
          OP_RL:   begin data_nxt.res = {v[6:0], cin};   data_nxt.cout = v[7]; end
          OP_RR:   begin data_nxt.res = {cin, v[7:1]};   data_nxt.cout = v[0]; end
          OP_SLA:  begin data_nxt.res = {v[6:0], 1'b0};  data_nxt.cout = v[7]; end
          OP_SRA:  begin data_nxt.res = {v[7], v[7:1]};  data_nxt.cout = v[0]; end
          OP_SLL:  begin data_nxt.res = {v[6:0], 1'b1};  data_nxt.cout = v[7]; end
          default: begin data_nxt.res = {1'b0, v[7:1]};  data_nxt.cout = v[0]; end
        endcase
      end
      GRP_RES: data_nxt.res = v & ~up_data.mask;
      GRP_SET: data_nxt.res = v | up_data.mask;
      default: data_nxt.res = 8'd0;
    endcase
    data_nxt.mw  = writes;
    data_nxt.rw  = writes && (up_data.rc != REG_MEM_ONLY);
    data_nxt.rs  = data_nxt.rw ? up_data.rc : 3'd0;
    data_nxt.cyc = writes ? CYC_WRITE : CYC_BIT;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[rtl/ibo_flags.sv]
module ibo_flags
  import ibo_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  s2_t       up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output out_word_t dn_word
);

  logic      valid_r, valid_nxt;
  out_word_t word_r, word_nxt;
  logic [7:0] r;
  logic [7:0] hi;
  logic       z;

  assign up_ready = !valid_r || dn_ready;

  // Flag byte and output word assembly
  always_comb begin
    r  = up_data.res;
    hi = up_data.addr[15:8];
    z  = !up_data.bit_set;
    case (up_data.grp)
      GRP_SHIFT: word_nxt.flags_out = {r[7], (r == 8'd0), r[5], 1'b0, r[3], ~^r, 1'b0,
                                       up_data.cout};
      GRP_BIT:   word_nxt.flags_out = {up_data.bit_sign && up_data.bit_set, z, hi[5], 1'b1,
                                       hi[3], z, 1'b0, up_data.flags[0]};
      default:   word_nxt.flags_out = up_data.flags;
    endcase
    word_nxt.pad         = '0;
    word_nxt.cycle_count = up_data.cyc;
    word_nxt.reg_select  = up_data.rs;
    word_nxt.reg_write   = up_data.rw;
    word_nxt.write_byte  = r;
    word_nxt.mem_write   = up_data.mw;
    word_nxt.mem_address = up_data.addr;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

[rtl/indexed_bit_op_unit_top.sv]
// Channel   Dir  Word                                            Handshake
// in_       in   48-bit word: operands of one DDCB/FDCB opcode   tvalid/tready
// out_      out  48-bit word: address, result, flags, T-states   tvalid/tready
//
// The pipe has three stages: decode/address, execute, flags. One word enters
// per cycle, and one word leaves per cycle, while out_tready stays high.
// Each stage holds its word until the next takes it, so out_tready low
// backs up stage by stage without loss; in_tready falls only when all full.
// rst_n (synchronous) clears the stage valid bits only.
module indexed_bit_op_unit_top
  import ibo_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // displacement[7:0], command[15:8], index_value[31:16], mem_byte[39:32],
  // flags_in[47:40]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // mem_address[15:0], mem_write[16], write_byte[24:17], reg_write[25],
  // reg_select[28:26], flags_out[36:29], cycle_count[41:37], zero[47:42]
  output logic [OUT_W-1:0] out_tdata
);

  in_word_t  in_word;
  out_word_t out_word;
  s1_t       s1_data;
  s2_t       s2_data;
  logic      s1_valid, s1_ready;
  logic      s2_valid, s2_ready;

  assign in_word = in_tdata;

  ibo_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_word  (in_word),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  ibo_exec u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  ibo_flags u_flags (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_word  (out_word)
  );

  assign out_tdata = out_word;

endmodule

[rtl/ibo_checker.sv]
`include "indexed_bit_op_unit_top_defines.svh"

module ibo_checker
  import ibo_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  out_word_t w;
  assign w = out_tdata;

  // A stalled word stays put
  `IBO_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata), "output word changed while stalled")

  // BIT: no write, zero byte, 20 T-states
  `IBO_ASSERT_IMP(a_bit_shape, out_tvalid && !w.mem_write,
                  w.write_byte == 8'd0 && w.reg_write == 1'b0 && w.cycle_count == CYC_BIT,
                  "BIT word inconsistent")

  // Writing groups take 23 T-states
  `IBO_ASSERT_IMP(a_write_cyc, out_tvalid && w.mem_write, w.cycle_count == CYC_WRITE,
                  "write word cycle count wrong")

  // Register copy never targets (HL); no copy means code zero
  `IBO_ASSERT_IMP(a_reg_sel, out_tvalid,
                  (w.reg_write && w.reg_select != REG_MEM_ONLY) ||
                  (!w.reg_write && w.reg_select == 3'd0),
                  "register select inconsistent")

endmodule

bind indexed_bit_op_unit_top ibo_checker u_ibo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
